FILE: design/bqc_pkg.sv
// Package: shared constants and types for the biquad chain.
package bqc_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int RAMP_STEP_DEF   = 137;
    localparam int FADE_FRAMES_DEF = 50;

    localparam int SW = 24;   // sample width
    localparam int DW = 32;   // delay and stage value width
    localparam int CW = 32;   // coefficient width
    localparam int VW = 17;   // volume scale width

    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_HPF_GAIN = 3'd1;
    localparam logic [2:0] REG_HPF_FB1  = 3'd2;
    localparam logic [2:0] REG_HPF_FB2  = 3'd3;
    localparam logic [2:0] REG_LPF_GAIN = 3'd4;
    localparam logic [2:0] REG_LPF_FB1  = 3'd5;
    localparam logic [2:0] REG_LPF_FB2  = 3'd6;
    localparam logic [2:0] REG_TARGET   = 3'd7;

    // Datapath operation selected by the controller each cycle.
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_LOAD  = 4'd1,   // read delays of stage 0, clear sum, form fade product
        OP_MUL   = 4'd2,   // multiply term selected by term index
        OP_ACC   = 4'd3,   // accumulate registered product
        OP_STAGE = 4'd4,   // saturate sum, write delays back, next stage
        OP_VMUL  = 4'd5,   // volume multiply
        OP_OUT   = 4'd6    // round and saturate into output register
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] term;   // 0:b0*x 1:b0*x1 2:b0*x2 3:a1*y1 4:a2*y2
        logic [1:0] stage;
    } t_cmd;

    typedef struct packed {
        logic hpf_on;
        logic lpf_on;
        logic ch_ok;
    } t_status;

endpackage

FILE: design/bqc_ctrl.sv
// Controller: sequences the biquad stages, volume multiply and output handshake.
module bqc_ctrl
    import bqc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    input  logic    i_out_free,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_STAGE = 7'b0010000,
        ST_VMUL  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_term, n_term;
    logic [1:0] r_stage, n_stage;

    function automatic logic stage_on(input logic [1:0] s, input t_status st);
        stage_on = st.ch_ok && (s[1] ? st.lpf_on : st.hpf_on);
    endfunction

    always_comb begin
        n_state = r_state;
        n_term  = r_term;
        n_stage = r_stage;
        o_cmd   = '{op: OP_NONE, term: r_term, stage: r_stage};
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.op = OP_LOAD;
                o_cmd.stage = 2'd0;
                n_stage = 2'd0;
                n_term  = 3'd0;
                n_state = stage_on(2'd0, i_status) ? ST_MUL : ST_STAGE;
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                if (r_term == 3'd4) begin
                    n_state = ST_STAGE;
                end else begin
                    n_term  = r_term + 3'd1;
                    n_state = ST_MUL;
                end
            end
            ST_STAGE: begin
                // Disabled stages pass the value through without touching delays.
                o_cmd.op = stage_on(r_stage, i_status) ? OP_STAGE : OP_NONE;
                n_term = 3'd0;
                if (r_stage == 2'd3) begin
                    n_state = ST_VMUL;
                end else begin
                    n_stage = r_stage + 2'd1;
                    n_state = stage_on(r_stage + 2'd1, i_status) ? ST_MUL : ST_STAGE;
                end
                o_cmd.stage = r_stage;
            end
            ST_VMUL: begin
                o_cmd.op = OP_VMUL;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_term  <= '0;
            r_stage <= '0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            r_stage <= n_stage;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> r_state == ST_LOAD)
        else $error("start not taken");
    a_term: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_term <= 3'd4)
        else $error("term out of range");

endmodule

FILE: design/bqc_dp.sv
// Datapath: delay memory, shared multiplier, accumulator, volume and fade.
module bqc_dp
    import bqc_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int RAMP_STEP   = RAMP_STEP_DEF,
    parameter int FADE_FRAMES = FADE_FRAMES_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_take,
    input  logic signed [SW-1:0] i_sample,
    input  logic [3:0]           i_channel,
    input  logic                 i_new_frame,
    input  logic                 i_restart,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic signed [SW-1:0] o_result,
    output logic [3:0]           o_channel_res
);

    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FW  = $clog2(FADE_FRAMES + 1);
    localparam int PW  = VW + FW;
    localparam int RK  = PW + FW;
    localparam int RW  = PW + 2;
    localparam longint RECIP = ((longint'(1) << RK) + longint'(FADE_FRAMES) - 1)
                               / longint'(FADE_FRAMES);

    // Delay memory per channel and stage: x1, x2, y1, y2.
    logic [4*DW-1:0] r_mem [CHANNELS*4];

    // One flag per channel and stage; a cleared flag makes that stage's delays read as zero.
    logic [CHANNELS*4-1:0] r_vld, n_vld;

    logic [1:0]           r_en;
    logic signed [CW-1:0] r_hg, r_h1, r_h2, r_lg, r_l1, r_l2;
    logic [6:0]           r_tv;
    logic [VW-1:0]        r_vol;
    logic [FW-1:0]        r_fade;

    logic [3:0]            r_ch;
    logic                  r_ch_ok;
    logic signed [DW-1:0]  r_x;          // value entering the current stage
    logic [4*DW-1:0]       r_rd;
    logic signed [63:0]    r_prod;
    logic signed [35:0]    r_acc;
    logic [PW-1:0]         r_fprod;
    logic [VW-1:0]         r_gain;
    logic signed [DW+VW:0] r_vprod;

    logic [1:0]           st;
    logic [CHW+1:0]       addr;
    logic signed [DW-1:0] d_x1, d_x2, d_y1, d_y2;
    logic                 d_ok;
    logic                 clr_h, clr_l;

    assign st   = i_cmd.stage;
    assign addr = {r_ch[CHW-1:0], st};

    assign d_ok = r_vld[addr];
    assign d_x1 = d_ok ? r_rd[4*DW-1:3*DW] : '0;
    assign d_x2 = d_ok ? r_rd[3*DW-1:2*DW] : '0;
    assign d_y1 = d_ok ? r_rd[2*DW-1:DW]   : '0;
    assign d_y2 = d_ok ? r_rd[DW-1:0]      : '0;

    assign o_status = '{hpf_on: r_en[0], lpf_on: r_en[1], ch_ok: r_ch_ok};

    // A coefficient write or an enable change clears the delays of its pair.
    assign clr_h = i_cfg_we && ((i_cfg_idx == REG_ENABLE && i_cfg_data[0] != r_en[0])
                   || i_cfg_idx == REG_HPF_GAIN || i_cfg_idx == REG_HPF_FB1
                   || i_cfg_idx == REG_HPF_FB2);
    assign clr_l = i_cfg_we && ((i_cfg_idx == REG_ENABLE && i_cfg_data[1] != r_en[1])
                   || i_cfg_idx == REG_LPF_GAIN || i_cfg_idx == REG_LPF_FB1
                   || i_cfg_idx == REG_LPF_FB2);

    always_comb begin
        n_vld = r_vld;
        for (int i = 0; i < CHANNELS*4; i++) begin
            if (i[1] ? clr_l : clr_h) n_vld[i] = 1'b0;
        end
        if (i_cmd.op == OP_STAGE) n_vld[addr] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '0;
            r_hg <= '0; r_h1 <= '0; r_h2 <= '0;
            r_lg <= '0; r_l1 <= '0; r_l2 <= '0;
            r_tv <= 7'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE:   r_en <= i_cfg_data[1:0];
                REG_HPF_GAIN: r_hg <= i_cfg_data;
                REG_HPF_FB1:  r_h1 <= i_cfg_data;
                REG_HPF_FB2:  r_h2 <= i_cfg_data;
                REG_LPF_GAIN: r_lg <= i_cfg_data;
                REG_LPF_FB1:  r_l1 <= i_cfg_data;
                REG_LPF_FB2:  r_l2 <= i_cfg_data;
                REG_TARGET:   r_tv <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Volume target and ramp.
    logic [6:0]     tv_c;
    logic [VW-1:0]  tgt;
    logic [VW-1:0]  n_vol;
    logic [VW-1:0]  steps [101];
    assign tv_c = (r_tv > 7'd100) ? 7'd100 : r_tv;
    always_comb begin
        for (int i = 0; i <= 100; i++) begin
            steps[i] = VW'((i * 65536 + 50) / 100);
        end
        tgt = steps[tv_c];
        if (r_vol < tgt) begin
            n_vol = (tgt - r_vol > VW'(RAMP_STEP)) ? r_vol + VW'(RAMP_STEP) : tgt;
        end else if (r_vol > tgt) begin
            n_vol = (r_vol - tgt > VW'(RAMP_STEP)) ? r_vol - VW'(RAMP_STEP) : tgt;
        end else begin
            n_vol = r_vol;
        end
    end

    // Fade gain: vol*fade/FADE_FRAMES by reciprocal multiplication, exact over the
    // whole range of the registered product.
    logic [PW+RW-1:0] fade_q;
    logic [VW-1:0]    fade_gain;
    assign fade_q = r_fprod * RW'(RECIP);
    always_comb begin
        fade_gain = r_vol;
        if (r_fade < FW'(FADE_FRAMES)) begin
            fade_gain = fade_q[RK+VW-1:RK];
        end
    end

    logic signed [CW-1:0] cg, ca1, ca2;
    logic signed [CW-1:0] mc;
    logic signed [DW-1:0] md;
    logic signed [35:0]   term_v;
    logic signed [35:0]   rnd;
    logic signed [DW-1:0] sat_v;

    assign cg   = st[1] ? r_lg : r_hg;
    assign ca1  = st[1] ? r_l1 : r_h1;
    assign ca2  = st[1] ? r_l2 : r_h2;

    always_comb begin
        case (i_cmd.term)
            3'd0: begin mc = cg;  md = r_x;  end
            3'd1: begin mc = cg;  md = d_x1; end
            3'd2: begin mc = cg;  md = d_x2; end
            3'd3: begin mc = ca1; md = d_y1; end
            default: begin mc = ca2; md = d_y2; end
        endcase
        rnd = 36'(($signed(r_prod) + 64'sd536870912) >>> 30);
        case (i_cmd.term)
            3'd1: term_v = st[1] ? (rnd <<< 1) : -(rnd <<< 1);
            3'd3, 3'd4: term_v = -rnd;
            default: term_v = rnd;
        endcase
        if (r_acc > 36'sh07FFFFFFF)       sat_v = 32'sh7FFFFFFF;
        else if (r_acc < -36'sh080000000) sat_v = 32'sh80000000;
        else                              sat_v = r_acc[DW-1:0];
    end

    logic signed [DW+VW+1:0] vr;
    assign vr = (r_vprod + (DW+VW+2)'(32768)) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol  <= '0;
            r_fade <= FW'(FADE_FRAMES);
        end else begin
            if (i_in_take && i_new_frame) begin
                r_vol <= n_vol;
                if (i_restart) r_fade <= '0;
                else if (r_fade < FW'(FADE_FRAMES)) r_fade <= r_fade + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_take) begin
            r_ch    <= i_channel;
            r_ch_ok <= ({1'b0, i_channel} < 5'(CHANNELS));
            r_x     <= DW'(i_sample);
        end
        r_gain <= fade_gain;
        case (i_cmd.op)
            OP_LOAD: begin
                r_rd    <= r_mem[{r_ch[CHW-1:0], 2'd0}];
                r_acc   <= '0;
                r_fprod <= r_vol * r_fade;
            end
            OP_MUL: r_prod <= 64'(mc) * 64'(md);
            OP_ACC: r_acc  <= r_acc + term_v;
            OP_STAGE: begin
                r_mem[addr] <= {r_x, d_x1, sat_v, d_y1};
                r_x   <= sat_v;
                r_acc <= '0;
            end
            OP_VMUL: begin
                r_vprod <= r_x * $signed({1'b0, r_gain});
            end
            OP_OUT: begin
                if (vr > (DW+VW+2)'(8388607))       o_result <= 24'sh7FFFFF;
                else if (vr < -(DW+VW+2)'(8388608)) o_result <= 24'sh800000;
                else                                 o_result <= vr[SW-1:0];
                o_channel_res <= r_ch;
            end
            default: ;
        endcase
        // Prefetch the next stage's delays while the current one finishes.
        if (i_cmd.op == OP_STAGE || (i_cmd.op == OP_NONE && r_ch_ok)) begin
            r_rd <= r_mem[{r_ch[CHW-1:0], st + 2'd1}];
        end
    end

endmodule

FILE: design/biquad_hpf_lpf_chain_with_volume_ramp_core.sv
// Top level: four-biquad filter chain with volume ramp and fade-in.
//  channel | direction | handshake       | payload
//  in      | input     | valid / ready   | sample_in, channel, new_frame, restart_fade
//  out     | output    | valid / ready   | sample_out, channel_out
//  cfg     | input     | write enable    | index, data
// One item passes through a load step, a multiply and an accumulate step for each term
// of every enabled stage, a stage step per stage, the volume multiply and the output
// step; the biquad terms share the single multiplier.
// Reset is synchronous and active low; delays read as zero after reset.
// The output register holds a result until taken; the next item is accepted
// as soon as the previous result has moved into the output register.
module biquad_hpf_lpf_chain_with_volume_ramp_core
    import bqc_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int RAMP_STEP   = RAMP_STEP_DEF,
    parameter int FADE_FRAMES = FADE_FRAMES_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [SW-1:0] i_sample_in,
    input  logic [2:0]           i_channel,
    input  logic                 i_new_frame,
    input  logic                 i_restart_fade,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [SW-1:0] o_sample_out,
    output logic [2:0]           o_channel_out
);

    t_cmd       cmd;
    t_status    status;
    logic       busy, take, out_free;
    logic       r_ov;
    logic [3:0] ch_res;

    assign o_in_ready = !busy;
    assign take       = i_in_valid && o_in_ready;
    assign out_free   = !r_ov || i_out_ready;

    bqc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(take), .i_status(status),
        .i_out_free(out_free), .o_cmd(cmd), .o_busy(busy)
    );

    bqc_dp #(.CHANNELS(CHANNELS), .RAMP_STEP(RAMP_STEP), .FADE_FRAMES(FADE_FRAMES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in_take(take), .i_sample(i_sample_in),
        .i_channel({1'b0, i_channel}), .i_new_frame(i_new_frame),
        .i_restart(i_restart_fade), .i_cmd(cmd), .o_status(status),
        .o_result(o_sample_out), .o_channel_res(ch_res)
    );

    assign o_channel_out = ch_res[2:0];
    assign o_out_valid   = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

endmodule

FILE: sim/biquad_hpf_lpf_chain_with_volume_ramp_core_test.sv
// Testbench for the biquad filter chain: random items, per-item prediction, field checks.
`timescale 1ns / 1ps

module biquad_hpf_lpf_chain_with_volume_ramp_core_test;
    import bqc_pkg::*;

    localparam int NCH = CHANNELS_DEF;
    localparam int STEP = RAMP_STEP_DEF;
    localparam int FADES = FADE_FRAMES_DEF;
    localparam int LIMIT = 900000;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic [2:0]           ch;
        logic                 nf;
        logic                 rf;
    } t_item;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic [2:0]           ch;
    } t_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [2:0]           i_cfg_idx = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [SW-1:0] i_sample_in = '0;
    logic [2:0]           i_channel = '0;
    logic                 i_new_frame = 1'b0;
    logic                 i_restart_fade = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [SW-1:0] o_sample_out;
    logic [2:0]           o_channel_out;

    biquad_hpf_lpf_chain_with_volume_ramp_core uut (.*);

    t_item pending_items[$];
    t_res  expected_results[$];
    int    errors = 0;
    int    cycles = 0;
    bit    calm = 0;
    bit    in_fire = 0;
    int    in_gap = 0;
    int    out_gap = 0;

    // Predictor copy of the block's state and registers.
    logic signed [31:0] delays[NCH][16];
    logic [16:0]        vol;
    logic [5:0]         fade;
    logic [1:0]         en_reg;
    logic signed [31:0] hg, h1, h2, lg, l1, l2;
    logic [6:0]         tvol;

    initial forever #4 i_clk = ~i_clk;

    function automatic void queue_item(t_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void queue_result(t_res r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic longint rnd(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic void clear_pair(int first);
        for (int c = 0; c < NCH; c++)
            for (int k = 0; k < 8; k++) delays[c][first * 4 + k] = 0;
    endfunction

    function automatic logic signed [31:0] biquad(int c, int base, logic signed [31:0] b0,
            longint b1m, logic signed [31:0] a1, logic signed [31:0] a2,
            logic signed [31:0] x);
        longint acc;
        logic signed [31:0] y;
        acc = rnd(longint'(b0) * x, 30) + b1m * rnd(longint'(b0) * delays[c][base], 30)
            + rnd(longint'(b0) * delays[c][base + 1], 30)
            - rnd(longint'(a1) * delays[c][base + 2], 30)
            - rnd(longint'(a2) * delays[c][base + 3], 30);
        if (acc > 64'sd2147483647) y = 32'h7fffffff;
        else if (acc < -64'sd2147483648) y = 32'h80000000;
        else y = acc[31:0];
        delays[c][base + 1] = delays[c][base];
        delays[c][base] = x;
        delays[c][base + 3] = delays[c][base + 2];
        delays[c][base + 2] = y;
        return y;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] d);
        logic [1:0] chg;
        case (idx)
            REG_ENABLE: begin
                chg = d[1:0] ^ en_reg;
                if (chg[0]) clear_pair(0);
                if (chg[1]) clear_pair(2);
                en_reg = d[1:0];
            end
            REG_HPF_GAIN: begin hg = d; clear_pair(0); end
            REG_HPF_FB1:  begin h1 = d; clear_pair(0); end
            REG_HPF_FB2:  begin h2 = d; clear_pair(0); end
            REG_LPF_GAIN: begin lg = d; clear_pair(2); end
            REG_LPF_FB1:  begin l1 = d; clear_pair(2); end
            REG_LPF_FB2:  begin l2 = d; clear_pair(2); end
            REG_TARGET:   tvol = d[6:0];
            default: ;
        endcase
    endfunction

    function automatic t_res filter_sample(t_item it);
        int unsigned tv, tgt;
        longint g, y;
        logic signed [31:0] v;
        t_res r;
        if (it.nf) begin
            tv = (tvol > 100) ? 100 : tvol;
            tgt = (tv * 65536 + 50) / 100;
            if (vol < tgt) vol = (tgt - vol > STEP) ? 17'(vol + STEP) : 17'(tgt);
            else if (vol > tgt) vol = (vol - tgt > STEP) ? 17'(vol - STEP) : 17'(tgt);
            if (it.rf) fade = 6'd0;
            else if (fade < FADES) fade = fade + 6'd1;
        end
        v = it.sample;
        if (it.ch < NCH) begin
            if (en_reg[0]) begin
                v = biquad(it.ch, 0, hg, -2, h1, h2, v);
                v = biquad(it.ch, 4, hg, -2, h1, h2, v);
            end
            if (en_reg[1]) begin
                v = biquad(it.ch, 8, lg, 2, l1, l2, v);
                v = biquad(it.ch, 12, lg, 2, l1, l2, v);
            end
        end
        g = vol;
        if (fade < FADES) g = (g * fade) / FADES;
        y = rnd(longint'(v) * g, 16);
        if (y > 8388607) y = 8388607;
        else if (y < -8388608) y = -8388608;
        r.sample = y[SW-1:0];
        r.ch = it.ch;
        return r;
    endfunction

    // Prediction, register tracking, checking and the watchdog share one clocked block.
    always @(posedge i_clk) begin
        t_res got, want;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else if (!i_rst_n) begin
            for (int c = 0; c < NCH; c++)
                for (int k = 0; k < 16; k++) delays[c][k] = 0;
            vol = 0; fade = FADES; en_reg = 0;
            hg = 0; h1 = 0; h2 = 0; lg = 0; l1 = 0; l2 = 0; tvol = 100;
            in_fire <= 1'b0;
        end else begin
            if (i_cfg_we) apply_reg(i_cfg_idx, i_cfg_data);
            in_fire <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready)
                queue_result(filter_sample(
                    '{i_sample_in, i_channel, i_new_frame, i_restart_fade}));
            if (o_out_valid && i_out_ready) begin
                got = '{o_sample_out, o_channel_out};
                if (expected_results.size() == 0) begin
                    $error("result with no item pending: sample_out %0d", got.sample);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.sample !== want.sample) begin
                        $error("sample_out expected %0d actual %0d", want.sample, got.sample);
                        errors++;
                    end
                    if (got.ch !== want.ch) begin
                        $error("channel_out expected %0d actual %0d", want.ch, got.ch);
                        errors++;
                    end
                end
            end
        end
    end

    // Item driver: holds valid until accepted, with random gaps between items.
    always @(negedge i_clk) begin
        if (i_rst_n && (in_fire || !i_in_valid)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!calm && i_in_valid && $urandom_range(0, 3) == 0) begin
                in_gap <= $urandom_range(0, 10);
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                t_item it;
                it = pending_items.pop_front();
                i_sample_in <= it.sample;
                i_channel <= it.ch;
                i_new_frame <= it.nf;
                i_restart_fade <= it.rf;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls in random bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            out_gap <= $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sampled at the rising edge so the driver's updates have settled.
    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic set_all(logic [1:0] en, logic [31:0] a, logic [31:0] b, logic [31:0] c,
            logic [31:0] d, logic [31:0] e, logic [31:0] f, logic [6:0] tv);
        reg_write(REG_HPF_GAIN, a);
        reg_write(REG_HPF_FB1, b);
        reg_write(REG_HPF_FB2, c);
        reg_write(REG_LPF_GAIN, d);
        reg_write(REG_LPF_FB1, e);
        reg_write(REG_LPF_FB2, f);
        reg_write(REG_TARGET, {25'd0, tv});
        reg_write(REG_ENABLE, {30'd0, en});
    endtask

    function automatic t_item rand_item();
        t_item it;
        case ($urandom_range(0, 7))
            0: it.sample = 24'sh7fffff;
            1: it.sample = 24'sh800000;
            2: it.sample = SW'($urandom_range(0, 255)) - 24'd128;
            default: it.sample = SW'($urandom);
        endcase
        it.ch = 3'($urandom_range(0, 7));
        it.nf = ($urandom_range(0, 3) == 0);
        it.rf = ($urandom_range(0, 25) == 0);
        return it;
    endfunction

    task automatic push_random(int n);
        for (int k = 0; k < n; k++) queue_item(rand_item());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at reset defaults: extremes, frame steps, restart without a frame.
        queue_item('{24'sh7fffff, 3'd0, 1'b1, 1'b0});
        queue_item('{24'sh800000, 3'd7, 1'b0, 1'b0});
        queue_item('{24'sh000000, 3'd1, 1'b1, 1'b1});
        queue_item('{-24'sd1, 3'd2, 1'b0, 1'b1});
        for (int k = 0; k < 12; k++)
            queue_item('{24'sh7fffff, 3'(k), 1'b1, 1'b0});
        drain();

        // Realistic Butterworth-like coefficients, both pairs on.
        set_all(2'd3, 32'sd1052266987, -32'sd2104533975, 32'sd1031633141,
                32'sd21474836, -32'sd1675037245, 32'sd687194767, 7'd100);
        queue_item('{24'sh7fffff, 3'd3, 1'b1, 1'b1});
        queue_item('{24'sh800000, 3'd3, 1'b0, 1'b0});
        push_random(300);
        drain();

        // Coefficient extremes with the high-pass pair only, volume ramping down to zero.
        set_all(2'd1, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h80000000, 7'd0);
        push_random(250);
        drain();

        // Random coefficients, low-pass only, target above the valid range.
        set_all(2'd2, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 7'd127);
        push_random(300);
        drain();

        // Enable toggles alone clear state; mid volume.
        reg_write(REG_ENABLE, 32'd3);
        reg_write(REG_TARGET, 32'd50);
        push_random(150);
        drain();
        set_all(2'd0, 32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 32'h80000000, 32'h7fffffff, 7'd100);
        push_random(150);
        drain();

        // Last part runs with no idling on either side.
        set_all(2'd3, 32'sd1052266987, -32'sd2104533975, 32'sd1031633141,
                $urandom, $urandom, $urandom, 7'($urandom_range(0, 100)));
        calm = 1;
        push_random(250);
        drain();
        repeat (100) @(negedge i_clk);

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
